/* sv/frm_pkg.sv */
`timescale 1ns / 1ps

package frm_pkg;

	// Number of fault table entries and the width of an entry number.
	localparam int ENTRY_MAX = 11;
	localparam int IDX_W     = 4;

	// Operation codes as they arrive on the operation port.
	localparam logic [2:0] OP_RAISE   = 3'd0;
	localparam logic [2:0] OP_DEBOUNCE = 3'd1;
	localparam logic [2:0] OP_CLEAR   = 3'd2;
	localparam logic [2:0] OP_RETRY   = 3'd3;
	localparam logic [2:0] OP_COOL    = 3'd4;
	localparam logic [2:0] OP_HEALTHY = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] REG_ENTRY_COUNT    = 3'd0;
	localparam logic [2:0] REG_FATAL_ENTRIES  = 3'd1;
	localparam logic [2:0] REG_RETRY_ENTRIES  = 3'd2;
	localparam logic [2:0] REG_RETRY_LIMITS   = 3'd3;
	localparam logic [2:0] REG_COOLDOWNS_LOW  = 3'd4;
	localparam logic [2:0] REG_COOLDOWNS_HIGH = 3'd5;
	localparam logic [2:0] REG_HEALTHY_PERIOD = 3'd6;

	// Command word handed from cell to cell along the chain.
	typedef struct packed {
		logic                 valid;
		logic [2:0]           op;
		logic [4:0]           fault_index;
		logic [7:0]           debounce_limit;
		logic [ENTRY_MAX-1:0] clear_mask;
		logic [15:0]          elapsed_ms;
		logic                 decided;      // retry outcome already settled upstream
		logic                 granted;
		logic                 raise;        // debounce threshold reached
		logic                 reset_counts; // healthy period reached
	} tok_t;

endpackage

/* sv/frm_cell.sv */
`timescale 1ns / 1ps

module frm_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  frm_pkg::tok_t               tok_in,
	output frm_pkg::tok_t               tok_out,
	input  logic [frm_pkg::IDX_W-1:0]   cell_index,
	input  logic                        used,
	input  logic                        retry_entry,
	input  logic                        active,
	input  logic [3:0]                  retry_limit,
	input  logic [9:0]                  cooldown,
	output logic                        escalated
);
	import frm_pkg::*;

	tok_t       tok_q, tok_d;
	logic [7:0] deb_q, deb_d, deb_inc;
	logic [3:0] cnt_q, cnt_d;
	logic [9:0] tmr_q, tmr_d;
	logic       esc_q, esc_d;

	assign deb_inc = (deb_q != 8'hFF) ? deb_q + 8'd1 : deb_q;

	always_comb begin
		tok_d = tok_in;
		deb_d = deb_q;
		cnt_d = cnt_q;
		tmr_d = tmr_q;
		esc_d = esc_q;
		if (tok_in.valid) begin
			case (tok_in.op)
				OP_DEBOUNCE: begin
					if (used && ({1'b0, cell_index} == tok_in.fault_index)) begin
						if (deb_inc >= tok_in.debounce_limit) begin
							deb_d = tok_in.debounce_limit;
							tok_d.raise = 1'b1;
						end else begin
							deb_d = deb_inc;
						end
					end
				end
				OP_CLEAR: begin
					if (used && tok_in.clear_mask[cell_index]) begin
						deb_d = 8'd0;
					end
				end
				OP_RETRY: begin
					if (!tok_in.decided && active && retry_entry) begin
						tok_d.decided = 1'b1;
						if (cnt_q >= retry_limit) begin
							esc_d = 1'b1;
						end else if (tmr_q == 10'd0) begin
							cnt_d = cnt_q + 4'd1;
							tmr_d = cooldown;
							tok_d.granted = 1'b1;
						end
					end
				end
				OP_COOL: begin
					if (used) begin
						if ({6'd0, tmr_q} > tok_in.elapsed_ms) begin
							tmr_d = tmr_q - tok_in.elapsed_ms[9:0];
						end else begin
							tmr_d = 10'd0;
						end
					end
				end
				OP_HEALTHY: begin
					if (tok_in.reset_counts && retry_entry) begin
						cnt_d = 4'd0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			deb_q <= 8'd0;
			cnt_q <= 4'd0;
			tmr_q <= 10'd0;
			esc_q <= 1'b0;
		end else begin
			tok_q <= tok_d;
			deb_q <= deb_d;
			cnt_q <= cnt_d;
			tmr_q <= tmr_d;
			esc_q <= esc_d;
		end
	end

	assign tok_out   = tok_q;
	assign escalated = esc_q;

endmodule

/* sv/fault_retry_manager.sv */
`timescale 1ns / 1ps

// Motor fault manager. A command word is taken when start is high while busy is low; its
// result word appears on active_faults, retry_granted and escalated_entries for exactly one
// cycle with done high. The receiver cannot hold a result off, so it must capture the word
// in the cycle that done is high. busy stays high from the accepting edge until the edge at
// which the word leaves the last cell, a register ahead of done, so a new command may be
// taken while the previous result is still being shown. The word is registered at launch,
// then walks through the row of eleven entry cells, each cell updating its own debounce
// counter, retry counter and cooldown timer as it passes; as it leaves the last cell the
// outcome is folded into the active fault mask and the result registers. Configuration is
// written through cfg_we, cfg_index and cfg_data and must only be changed while busy is low.
module fault_retry_manager (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [4:0]  fault_index,
	input  logic [7:0]  debounce_limit,
	input  logic [31:0] clear_mask,
	input  logic [15:0] elapsed_ms,
	output logic        done,
	output logic [31:0] active_faults,
	output logic        retry_granted,
	output logic [10:0] escalated_entries,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [59:0] cfg_data
);
	import frm_pkg::*;

	// Configuration registers.
	logic [3:0]  entry_count_q;
	logic [10:0] fatal_entries_q;
	logic [10:0] retry_entries_q;
	logic [43:0] retry_limits_q;
	logic [59:0] cooldowns_low_q;
	logic [49:0] cooldowns_high_q;
	logic [15:0] healthy_period_q;

	// Block state held outside the cells.
	logic [31:0] active_q;
	logic [16:0] acc_q;
	logic        busy_q;

	// The command is kept here so that the mask can be updated once the chain is done.
	logic [2:0]  op_q;
	logic [4:0]  idx_q;
	logic [31:0] mask_q;

	// Result word registers.
	logic        done_q;
	logic [31:0] res_active_q;
	logic        res_granted_q;
	logic [10:0] res_esc_q;

	tok_t                 tok [0:ENTRY_MAX];
	tok_t                 launch_q, launch_d;
	logic [ENTRY_MAX-1:0] used_mask, auto_set, fatal_set, esc_bits;
	logic [3:0]           used_count;
	logic [16:0]          acc_sum;
	logic                 accept, period_reached;
	logic [31:0]          raise_bit, next_active;

	assign accept = start && !busy_q;

	// An entry count above the table size behaves as the table size.
	assign used_count = (entry_count_q > 4'(ENTRY_MAX)) ? 4'(ENTRY_MAX) : entry_count_q;

	always_comb begin
		for (int i = 0; i < ENTRY_MAX; i++) begin
			used_mask[i] = (4'(i) < used_count);
		end
	end

	// Fatal severity wins over auto retry for an entry marked as both.
	assign auto_set  = retry_entries_q & ~fatal_entries_q & used_mask;
	assign fatal_set = (fatal_entries_q | esc_bits) & used_mask;

	// The healthy accumulator is seventeen bits wide and cannot overflow; a period of zero is reached on every tick.
	assign acc_sum        = acc_q + {1'b0, elapsed_ms};
	assign period_reached = (acc_sum >= {1'b0, healthy_period_q});

	always_comb begin
		launch_d                = '0;
		launch_d.valid          = accept;
		launch_d.op             = operation;
		launch_d.fault_index    = fault_index;
		launch_d.debounce_limit = debounce_limit;
		launch_d.clear_mask     = clear_mask[ENTRY_MAX-1:0];
		launch_d.elapsed_ms     = elapsed_ms;
		// A retry is refused outright while a fatal fault is active or nothing is active.
		launch_d.decided        = ((active_q[ENTRY_MAX-1:0] & fatal_set) != '0)
		                          || (active_q == 32'd0);
		launch_d.reset_counts   = (operation == OP_HEALTHY) && period_reached;
	end

	assign tok[0] = launch_q;

	for (genvar i = 0; i < ENTRY_MAX; i++) begin : g_cell
		logic [9:0] cooldown_i;
		if (i < 6) begin : g_low
			assign cooldown_i = cooldowns_low_q[10*i +: 10];
		end else begin : g_high
			assign cooldown_i = cooldowns_high_q[10*(i-6) +: 10];
		end

		frm_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.tok_in      (tok[i]),
			.tok_out     (tok[i+1]),
			.cell_index  (IDX_W'(i)),
			.used        (used_mask[i]),
			.retry_entry (auto_set[i]),
			.active      (active_q[i]),
			.retry_limit (retry_limits_q[4*i +: 4]),
			.cooldown    (cooldown_i),
			.escalated   (esc_bits[i])
		);
	end

	// Fold the outcome of the chain into the active fault mask.
	assign raise_bit = 32'd1 << idx_q;

	always_comb begin
		next_active = active_q;
		case (op_q)
			OP_RAISE: begin
				next_active = active_q | raise_bit;
			end
			OP_DEBOUNCE: begin
				// A bit outside the table in use is raised at once.
				if (({1'b0, idx_q} >= {2'b00, used_count}) || tok[ENTRY_MAX].raise) begin
					next_active = active_q | raise_bit;
				end
			end
			OP_CLEAR: begin
				next_active = active_q & ~mask_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q    <= 4'd11;
			fatal_entries_q  <= 11'd1409;
			retry_entries_q  <= 11'd638;
			retry_limits_q   <= 44'd206177378849;
			cooldowns_low_q  <= 60'd564049679789680500;
			cooldowns_high_q <= 50'd536870912500;
			healthy_period_q <= 16'd30000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY_COUNT:    entry_count_q    <= cfg_data[3:0];
				REG_FATAL_ENTRIES:  fatal_entries_q  <= cfg_data[10:0];
				REG_RETRY_ENTRIES:  retry_entries_q  <= cfg_data[10:0];
				REG_RETRY_LIMITS:   retry_limits_q   <= cfg_data[43:0];
				REG_COOLDOWNS_LOW:  cooldowns_low_q  <= cfg_data[59:0];
				REG_COOLDOWNS_HIGH: cooldowns_high_q <= cfg_data[49:0];
				REG_HEALTHY_PERIOD: healthy_period_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			active_q <= 32'd0;
			acc_q    <= 17'd0;
		end else begin
			launch_q <= launch_d;
			done_q   <= tok[ENTRY_MAX].valid;
			if (accept) begin
				busy_q <= 1'b1;
				if (operation == OP_HEALTHY) begin
					acc_q <= period_reached ? 17'd0 : acc_sum;
				end
			end else if (tok[ENTRY_MAX].valid) begin
				busy_q   <= 1'b0;
				active_q <= next_active;
			end
		end
	end

	// Command and result payload registers need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			idx_q  <= fault_index;
			mask_q <= clear_mask;
		end
		if (tok[ENTRY_MAX].valid) begin
			res_active_q  <= next_active;
			res_granted_q <= tok[ENTRY_MAX].granted;
			res_esc_q     <= esc_bits;
		end
	end

	assign busy              = busy_q;
	assign done              = done_q;
	assign active_faults     = res_active_q;
	assign retry_granted     = res_granted_q;
	assign escalated_entries = res_esc_q;

	// A taken command always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("accepted command did not raise busy");

	// A result word only follows a busy period.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("result word without a command in flight");

	// Only a retry request can be granted.
	a_grant_retry: assert property (@(posedge clk) disable iff (!arst_n)
		tok[ENTRY_MAX].valid && tok[ENTRY_MAX].granted |-> op_q == OP_RETRY)
		else $error("grant on an operation other than retry");

	// Escalation is never undone by anything short of reset.
	a_esc_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		($past(esc_bits) & ~esc_bits) == '0)
		else $error("escalated entry was cleared");

endmodule
